// ===== rtl/spr_pkg.sv =====
package spr_pkg;

    localparam int SQRT_CELLS   = 30;
    localparam int DIV_CELLS    = 31;
    localparam int QUAD_CELLS   = 7;
    localparam int HORNER_CELLS = 5;

    localparam logic [15:0] TIME_STEP_RST = 16'd1311;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [30:0] HALF_PI    = 31'd1686629713;
    localparam logic [29:0] QUARTER_PI = 30'd843314856;

    localparam logic signed [63:0] SPIN_LIM = 64'sd16384;

    // ceil(2^38 / divisor) for the Horner steps, exact for operands below 2^31
    typedef logic [37:0] t_recip;
    localparam t_recip SIN_RECIP [HORNER_CELLS] = '{
        38'd2498890064,   // 1/110
        38'd3817748708,   // 1/72
        38'd6544712071,   // 1/42
        38'd13743895348,  // 1/20
        38'd45812984491   // 1/6
    };
    localparam t_recip COS_RECIP [HORNER_CELLS] = '{
        38'd3054198967,   // 1/90
        38'd4908534053,   // 1/56
        38'd9162596899,   // 1/30
        38'd22906492246,  // 1/12
        38'd137438953472  // 1/2
    };

    typedef struct packed {
        logic [2:0][15:0] v;
        logic [2:0][17:0] h;
        logic             hs;
        logic             zero;
    } t_pre;

    typedef struct packed {
        logic [2:0][15:0] v;
        logic [2:0]       neg;
        logic             hs;
        logic             zero;
        logic [45:0]      prod;
    } t_div;

    typedef struct packed {
        logic [2:0][15:0] v;
        logic [2:0][31:0] a;
        logic             zero;
    } t_rot;

    typedef struct packed {
        t_rot        rot;
        logic [31:0] r;
        logic [1:0]  quad;
    } t_hc;

    // round half away from zero, divide by 2^30
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
        logic        neg;
        logic [63:0] m;
        neg = x[63];
        m   = neg ? 64'(-x) : 64'(x);
        m   = (m + 64'h2000_0000) >> 30;
        return neg ? -signed'(m) : signed'(m);
    endfunction

    function automatic logic [15:0] sat_spin(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x;
        if (y > SPIN_LIM) begin
            y = SPIN_LIM;
        end
        if (y < -SPIN_LIM) begin
            y = -SPIN_LIM;
        end
        return y[15:0];
    endfunction

endpackage

// ===== rtl/spr_if.sv =====
interface spr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] spin_x;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_z;
    logic signed [17:0] field_x;
    logic signed [17:0] field_y;
    logic signed [17:0] field_z;
    logic               half_step;

    modport source (output valid, spin_x, spin_y, spin_z, field_x, field_y, field_z,
                    half_step, input ready);
    modport sink   (input valid, spin_x, spin_y, spin_z, field_x, field_y, field_z,
                    half_step, output ready);
endinterface

interface spr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_spin_x;
    logic signed [15:0] new_spin_y;
    logic signed [15:0] new_spin_z;
    logic               zero_field;

    modport source (output valid, new_spin_x, new_spin_y, new_spin_z, zero_field,
                    input ready);
    modport sink   (input valid, new_spin_x, new_spin_y, new_spin_z, zero_field,
                    output ready);
endinterface

// ===== rtl/spr_sqrt_cell.sv =====
module spr_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_vld,
    input  logic [59:0]   i_rad,
    input  logic [31:0]   i_rem,
    input  logic [29:0]   i_root,
    input  spr_pkg::t_pre i_car,
    output logic          o_vld,
    output logic [59:0]   o_rad,
    output logic [31:0]   o_rem,
    output logic [29:0]   o_root,
    output spr_pkg::t_pre o_car
);
    logic [33:0]   w_win;
    logic [33:0]   w_trial;
    logic          w_fit;
    logic          r_vld;
    logic [59:0]   r_rad;
    logic [31:0]   r_rem;
    logic [29:0]   r_root;
    spr_pkg::t_pre r_car;

    // one root bit per cell: bring down two radicand bits, try 4*root+1
    assign w_win   = {i_rem, i_rad[59:58]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_fit   = (w_win >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rad  <= {i_rad[57:0], 2'b00};
            r_rem  <= w_fit ? 32'(w_win - w_trial) : w_win[31:0];
            r_root <= {i_root[28:0], w_fit};
            r_car  <= i_car;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_car  = r_car;
endmodule

// ===== rtl/spr_div_cell.sv =====
module spr_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [29:0]      i_den,
    input  logic [30:0]      i_low,
    input  logic [2:0][30:0] i_rem,
    input  logic [2:0][30:0] i_quo,
    input  spr_pkg::t_div    i_car,
    output logic             o_vld,
    output logic [29:0]      o_den,
    output logic [30:0]      o_low,
    output logic [2:0][30:0] o_rem,
    output logic [2:0][30:0] o_quo,
    output spr_pkg::t_div    o_car
);
    logic [2:0][31:0] w_win;
    logic [2:0]       w_fit;
    logic             r_vld;
    logic [29:0]      r_den;
    logic [30:0]      r_low;
    logic [2:0][30:0] r_rem;
    logic [2:0][30:0] r_quo;
    spr_pkg::t_div    r_car;

    // three restoring-division lanes share the denominator and the low bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_win[k] = {i_rem[k], i_low[30]};
            w_fit[k] = (w_win[k] >= {2'b00, i_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_den <= i_den;
            r_low <= {i_low[29:0], 1'b0};
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= w_fit[k] ? 31'(w_win[k] - {2'b00, i_den}) : w_win[k][30:0];
                r_quo[k] <= {i_quo[k][29:0], w_fit[k]};
            end
            r_car <= i_car;
        end
    end

    assign o_vld = r_vld;
    assign o_den = r_den;
    assign o_low = r_low;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_car = r_car;
endmodule

// ===== rtl/spr_horner_cell.sv =====
module spr_horner_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_vld,
    input  logic [29:0]          i_x2,
    input  logic [30:0]          i_s,
    input  logic [30:0]          i_c,
    input  spr_pkg::t_recip      i_ms,
    input  spr_pkg::t_recip      i_mc,
    input  spr_pkg::t_hc         i_car,
    output logic                 o_vld,
    output logic [29:0]          o_x2,
    output logic [30:0]          o_s,
    output logic [30:0]          o_c,
    output spr_pkg::t_hc         o_car
);
    // three stages per Horner step: x2*acc, round and scale by 1/k, 1 - result
    logic [2:0]           r_vld;
    logic [2:0][29:0]     r_x2;
    spr_pkg::t_hc [2:0]   r_car;
    logic [60:0]          r_ps;
    logic [60:0]          r_pc;
    logic [68:0]          r_ts;
    logic [68:0]          r_tc;
    logic [30:0]          r_s;
    logic [30:0]          r_c;
    logic [60:0]          w_ys;
    logic [60:0]          w_yc;

    assign w_ys = r_ps + 61'h2000_0000;
    assign w_yc = r_pc + 61'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x2  <= {r_x2[1:0], i_x2};
            r_car <= {r_car[1:0], i_car};
            r_ps  <= 61'(i_x2) * 61'(i_s);
            r_pc  <= 61'(i_x2) * 61'(i_c);
            r_ts  <= 69'(w_ys[60:30]) * 69'(i_ms);
            r_tc  <= 69'(w_yc[60:30]) * 69'(i_mc);
            r_s   <= spr_pkg::Q30_ONE - r_ts[68:38];
            r_c   <= spr_pkg::Q30_ONE - r_tc[68:38];
        end
    end

    assign o_vld = r_vld[2];
    assign o_x2  = r_x2[2];
    assign o_car = r_car[2];
    assign o_s   = r_s;
    assign o_c   = r_c;
endmodule

// ===== rtl/spin_precession_rotation.sv =====
// channel   dir  transaction payload
// i_in      in   spin_x/y/z Q1.14, field_x/y/z Q5.12, half_step
// o_out     out  new_spin_x/y/z Q1.14 saturated, zero_field
// cfg       in   i_cfg_we / i_cfg_wdata write time_step (dt, 2^-16 units)
//
// one transaction per cycle while the output is not stalled
// the main parts of the pipeline are the 30-cell square-root chain, the 31-cell divider chain,
// the 7-cell quadrant reduction and five 3-stage Horner cells for sin/cos
// all stages advance together; a stalled output holds the whole pipeline
// synchronous active-low reset clears valid bits and loads time_step = 1311
module spin_precession_rotation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    spr_in_if.sink            i_in,
    spr_out_if.source         o_out
);
    localparam int NS = spr_pkg::SQRT_CELLS;
    localparam int ND = spr_pkg::DIV_CELLS;
    localparam int NQ = spr_pkg::QUAD_CELLS;
    localparam int NH = spr_pkg::HORNER_CELLS;

    logic        w_adv;
    logic [15:0] r_time_step;
    logic        r_out_vld;

    assign w_adv      = !r_out_vld || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= spr_pkg::TIME_STEP_RST;
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_wdata;
        end
    end

    // squares, then radicand
    logic                   r_s1_vld;
    spr_pkg::t_pre          r_s1_car;
    logic [2:0][35:0]       r_s1_sq;
    logic                   r_s2_vld;
    spr_pkg::t_pre          r_s2_car;
    logic [59:0]            r_s2_rad;
    logic [35:0]            w_mag2;
    logic signed [35:0]     w_sqx;
    logic signed [35:0]     w_sqy;
    logic signed [35:0]     w_sqz;

    assign w_sqx  = i_in.field_x * i_in.field_x;
    assign w_sqy  = i_in.field_y * i_in.field_y;
    assign w_sqz  = i_in.field_z * i_in.field_z;
    assign w_mag2 = r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_in.valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_car.v    <= {i_in.spin_z, i_in.spin_y, i_in.spin_x};
            r_s1_car.h    <= {i_in.field_z, i_in.field_y, i_in.field_x};
            r_s1_car.hs   <= i_in.half_step;
            r_s1_car.zero <= 1'b0;
            r_s1_sq       <= {w_sqz, w_sqy, w_sqx};
            r_s2_car.v    <= r_s1_car.v;
            r_s2_car.h    <= r_s1_car.h;
            r_s2_car.hs   <= r_s1_car.hs;
            r_s2_car.zero <= (w_mag2 == 36'd0);
            r_s2_rad      <= {w_mag2, 24'd0};
        end
    end

    // square-root chain
    logic          w_sq_vld  [NS+1];
    logic [59:0]   w_sq_rad  [NS+1];
    logic [31:0]   w_sq_rem  [NS+1];
    logic [29:0]   w_sq_root [NS+1];
    spr_pkg::t_pre w_sq_car  [NS+1];

    assign w_sq_vld[0]  = r_s2_vld;
    assign w_sq_rad[0]  = r_s2_rad;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_car[0]  = r_s2_car;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        spr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_sq_vld[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_car   (w_sq_car[g]),
            .o_vld   (w_sq_vld[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_car   (w_sq_car[g+1])
        );
    end

    // divider setup: numerator h<<42 + R/2, and R*dt for the angle
    logic             r_c_vld;
    logic [29:0]      r_c_den;
    logic [30:0]      r_c_low;
    logic [2:0][30:0] r_c_rem;
    spr_pkg::t_div    r_c_car;
    spr_pkg::t_pre    w_pre;
    logic [29:0]      w_root;

    assign w_pre  = w_sq_car[NS];
    assign w_root = w_sq_root[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= w_sq_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_den <= w_root;
            r_c_low <= {2'b00, w_root[29:1]};
            for (int k = 0; k < 3; k++) begin
                r_c_rem[k]     <= {w_pre.h[k][17] ? 18'(-w_pre.h[k]) : w_pre.h[k], 11'd0, 2'b00}
                                  >> 2;
                r_c_car.neg[k] <= w_pre.h[k][17];
            end
            r_c_car.v    <= w_pre.v;
            r_c_car.hs   <= w_pre.hs;
            r_c_car.zero <= w_pre.zero;
            r_c_car.prod <= 46'(w_root) * 46'(r_time_step);
        end
    end

    // divider chain
    logic             w_dv_vld [ND+1];
    logic [29:0]      w_dv_den [ND+1];
    logic [30:0]      w_dv_low [ND+1];
    logic [2:0][30:0] w_dv_rem [ND+1];
    logic [2:0][30:0] w_dv_quo [ND+1];
    spr_pkg::t_div    w_dv_car [ND+1];

    assign w_dv_vld[0] = r_c_vld;
    assign w_dv_den[0] = r_c_den;
    assign w_dv_low[0] = r_c_low;
    assign w_dv_rem[0] = r_c_rem;
    assign w_dv_quo[0] = '0;
    assign w_dv_car[0] = r_c_car;

    for (genvar g = 0; g < ND; g++) begin : g_div
        spr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_dv_vld[g]),
            .i_den   (w_dv_den[g]),
            .i_low   (w_dv_low[g]),
            .i_rem   (w_dv_rem[g]),
            .i_quo   (w_dv_quo[g]),
            .i_car   (w_dv_car[g]),
            .o_vld   (w_dv_vld[g+1]),
            .o_den   (w_dv_den[g+1]),
            .o_low   (w_dv_low[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_quo   (w_dv_quo[g+1]),
            .o_car   (w_dv_car[g+1])
        );
    end

    // axis sign, angle rounding and quadrant reduction
    spr_pkg::t_div w_dvo;
    logic [46:0]   w_th_sum;
    logic [36:0]   w_theta;
    logic [36:0]   w_tq;

    assign w_dvo    = w_dv_car[ND];
    assign w_th_sum = w_dvo.hs ? (47'(w_dvo.prod) + 47'd1024) : (47'(w_dvo.prod) + 47'd512);
    assign w_theta  = w_dvo.hs ? {1'b0, w_th_sum[46:11]} : w_th_sum[46:10];
    assign w_tq     = w_theta + 37'(spr_pkg::QUARTER_PI);

    logic          r_q_vld [NQ+1];
    logic [30:0]   r_q_rem [NQ+1];
    logic [6:0]    r_q_low [NQ+1];
    logic [6:0]    r_q_quo [NQ+1];
    spr_pkg::t_rot r_q_car [NQ+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_q_vld[0] <= w_dv_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_rem[0] <= {1'b0, w_tq[36:7]};
            r_q_low[0] <= w_tq[6:0];
            r_q_quo[0] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_q_car[0].a[k] <= w_dvo.neg[k] ? 32'(-{1'b0, w_dv_quo[ND][k]})
                                                : {1'b0, w_dv_quo[ND][k]};
            end
            r_q_car[0].v    <= w_dvo.v;
            r_q_car[0].zero <= w_dvo.zero;
        end
    end

    for (genvar g = 0; g < NQ; g++) begin : g_quad
        logic [31:0] w_win;
        logic        w_fit;

        assign w_win = {r_q_rem[g], r_q_low[g][6]};
        assign w_fit = (w_win >= {1'b0, spr_pkg::HALF_PI});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_q_vld[g+1] <= r_q_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_q_rem[g+1] <= w_fit ? 31'(w_win - {1'b0, spr_pkg::HALF_PI}) : w_win[30:0];
                r_q_low[g+1] <= {r_q_low[g][5:0], 1'b0};
                r_q_quo[g+1] <= {r_q_quo[g][5:0], w_fit};
                r_q_car[g+1] <= r_q_car[g];
            end
        end
    end

    // reduced angle and its square
    logic               r_f0_vld;
    logic               r_f1_vld;
    logic               r_f2_vld;
    spr_pkg::t_hc       r_f0_car;
    spr_pkg::t_hc       r_f1_car;
    spr_pkg::t_hc       r_f2_car;
    logic [59:0]        r_f1_sq;
    logic [29:0]        r_f2_x2;
    logic signed [63:0] w_rr;
    logic [60:0]        w_x2_sum;

    assign w_rr     = signed'(r_f0_car.r) * signed'(r_f0_car.r);
    assign w_x2_sum = 61'(r_f1_sq) + 61'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f0_vld <= r_q_vld[NQ];
            r_f1_vld <= r_f0_vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f0_car.rot  <= r_q_car[NQ];
            r_f0_car.r    <= {1'b0, r_q_rem[NQ]} - {2'b00, spr_pkg::QUARTER_PI};
            r_f0_car.quad <= r_q_quo[NQ][1:0];
            r_f1_car      <= r_f0_car;
            r_f1_sq       <= w_rr[59:0];
            r_f2_car      <= r_f1_car;
            r_f2_x2       <= w_x2_sum[59:30];
        end
    end

    // sin/cos Horner chain
    logic         w_hn_vld [NH+1];
    logic [29:0]  w_hn_x2  [NH+1];
    logic [30:0]  w_hn_s   [NH+1];
    logic [30:0]  w_hn_c   [NH+1];
    spr_pkg::t_hc w_hn_car [NH+1];

    assign w_hn_vld[0] = r_f2_vld;
    assign w_hn_x2[0]  = r_f2_x2;
    assign w_hn_s[0]   = spr_pkg::Q30_ONE;
    assign w_hn_c[0]   = spr_pkg::Q30_ONE;
    assign w_hn_car[0] = r_f2_car;

    for (genvar g = 0; g < NH; g++) begin : g_horner
        spr_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_hn_vld[g]),
            .i_x2    (w_hn_x2[g]),
            .i_s     (w_hn_s[g]),
            .i_c     (w_hn_c[g]),
            .i_ms    (spr_pkg::SIN_RECIP[g]),
            .i_mc    (spr_pkg::COS_RECIP[g]),
            .i_car   (w_hn_car[g]),
            .o_vld   (w_hn_vld[g+1]),
            .o_x2    (w_hn_x2[g+1]),
            .o_s     (w_hn_s[g+1]),
            .o_c     (w_hn_c[g+1]),
            .o_car   (w_hn_car[g+1])
        );
    end

    // rotation
    spr_pkg::t_hc w_hno;
    assign w_hno = w_hn_car[NH];

    logic                   r_g1_vld;
    logic                   r_g2_vld;
    logic                   r_g3_vld;
    logic                   r_g4_vld;
    spr_pkg::t_rot          r_g1_car;
    spr_pkg::t_rot          r_g2_car;
    spr_pkg::t_rot          r_g3_car;
    spr_pkg::t_rot          r_g4_car;
    logic signed [62:0]     r_g1_ps;
    logic [30:0]            r_g1_c;
    logic [1:0]             r_g1_quad;
    logic signed [47:0]     r_g1_av [3][3];
    logic signed [31:0]     r_g2_sn;
    logic signed [31:0]     r_g2_cs;
    logic signed [17:0]     r_g2_d;
    logic signed [17:0]     r_g2_cr [3];
    logic signed [31:0]     r_g3_sn;
    logic signed [32:0]     r_g3_omc;
    logic signed [17:0]     r_g3_cr [3];
    logic signed [47:0]     r_g3_t1 [3];
    logic signed [49:0]     r_g3_md [3];
    logic signed [47:0]     r_g4_t1 [3];
    logic signed [50:0]     r_g4_t2 [3];
    logic signed [49:0]     r_g4_t3 [3];
    logic signed [31:0]     w_s0;
    logic signed [31:0]     w_c0;
    logic signed [63:0]     w_dot;
    logic signed [63:0]     w_crs [3];
    logic signed [63:0]     w_mdr [3];
    logic signed [63:0]     w_sum [3];

    assign w_s0  = 32'(spr_pkg::rnd30(64'(r_g1_ps)));
    assign w_c0  = signed'({1'b0, r_g1_c});
    assign w_dot = 64'(r_g1_av[0][0]) + 64'(r_g1_av[1][1]) + 64'(r_g1_av[2][2]);

    always_comb begin
        w_crs[0] = 64'(r_g1_av[1][2]) - 64'(r_g1_av[2][1]);
        w_crs[1] = 64'(r_g1_av[2][0]) - 64'(r_g1_av[0][2]);
        w_crs[2] = 64'(r_g1_av[0][1]) - 64'(r_g1_av[1][0]);
        for (int k = 0; k < 3; k++) begin
            w_mdr[k] = spr_pkg::rnd30(64'(r_g3_md[k]));
            w_sum[k] = 64'(r_g4_t1[k]) + 64'(r_g4_t2[k]) - 64'(r_g4_t3[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_vld  <= 1'b0;
            r_g2_vld  <= 1'b0;
            r_g3_vld  <= 1'b0;
            r_g4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_g1_vld  <= w_hn_vld[NH];
            r_g2_vld  <= r_g1_vld;
            r_g3_vld  <= r_g2_vld;
            r_g4_vld  <= r_g3_vld;
            r_out_vld <= r_g4_vld;
        end
    end

    logic [15:0] r_out_x;
    logic [15:0] r_out_y;
    logic [15:0] r_out_z;
    logic        r_out_zero;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g1_car  <= w_hno.rot;
            r_g1_ps   <= signed'(w_hno.r) * signed'({1'b0, w_hn_s[NH]});
            r_g1_c    <= w_hn_c[NH];
            r_g1_quad <= w_hno.quad;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_g1_av[k][j] <= signed'(w_hno.rot.a[k]) * signed'(w_hno.rot.v[j]);
                end
            end

            r_g2_car <= r_g1_car;
            case (r_g1_quad)
                2'd0: begin
                    r_g2_sn <= w_s0;
                    r_g2_cs <= w_c0;
                end
                2'd1: begin
                    r_g2_sn <= w_c0;
                    r_g2_cs <= -w_s0;
                end
                2'd2: begin
                    r_g2_sn <= -w_s0;
                    r_g2_cs <= -w_c0;
                end
                default: begin
                    r_g2_sn <= -w_c0;
                    r_g2_cs <= w_s0;
                end
            endcase
            r_g2_d <= 18'(spr_pkg::rnd30(w_dot));
            for (int k = 0; k < 3; k++) begin
                r_g2_cr[k] <= 18'(spr_pkg::rnd30(w_crs[k]));
            end

            r_g3_car <= r_g2_car;
            r_g3_sn  <= r_g2_sn;
            r_g3_omc <= signed'({2'b00, spr_pkg::Q30_ONE}) - 33'(r_g2_cs);
            for (int k = 0; k < 3; k++) begin
                r_g3_cr[k] <= r_g2_cr[k];
                r_g3_t1[k] <= signed'(r_g2_car.v[k]) * r_g2_cs;
                r_g3_md[k] <= signed'(r_g2_car.a[k]) * r_g2_d;
            end

            r_g4_car <= r_g3_car;
            for (int k = 0; k < 3; k++) begin
                r_g4_t1[k] <= r_g3_t1[k];
                r_g4_t2[k] <= 18'(w_mdr[k]) * r_g3_omc;
                r_g4_t3[k] <= r_g3_cr[k] * r_g3_sn;
            end

            r_out_zero <= r_g4_car.zero;
            if (r_g4_car.zero) begin
                r_out_x <= spr_pkg::sat_spin(64'(signed'(r_g4_car.v[0])));
                r_out_y <= spr_pkg::sat_spin(64'(signed'(r_g4_car.v[1])));
                r_out_z <= spr_pkg::sat_spin(64'(signed'(r_g4_car.v[2])));
            end else begin
                r_out_x <= spr_pkg::sat_spin(spr_pkg::rnd30(w_sum[0]));
                r_out_y <= spr_pkg::sat_spin(spr_pkg::rnd30(w_sum[1]));
                r_out_z <= spr_pkg::sat_spin(spr_pkg::rnd30(w_sum[2]));
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.new_spin_x = r_out_x;
    assign o_out.new_spin_y = r_out_y;
    assign o_out.new_spin_z = r_out_z;
    assign o_out.zero_field = r_out_zero;
endmodule

// ===== rtl/spr_checker.sv =====
module spr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_new_spin_x,
    input logic [15:0] i_new_spin_y,
    input logic [15:0] i_new_spin_z
);
    // each result component stays within +-16384 (+-1.0 in Q1.14) after saturation
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_new_spin_x) <= 16'sd16384)
                     && ($signed(i_new_spin_x) >= -16'sd16384)
                     && ($signed(i_new_spin_y) <= 16'sd16384)
                     && ($signed(i_new_spin_y) >= -16'sd16384)
                     && ($signed(i_new_spin_z) <= 16'sd16384)
                     && ($signed(i_new_spin_z) >= -16'sd16384))
        else $error("saturation bound violated");

    // input side only stalls when a result is held back
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_new_spin_x)
                                          && $stable(i_new_spin_y) && $stable(i_new_spin_z))
        else $error("stalled result changed");
endmodule

bind spin_precession_rotation spr_checker u_spr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_new_spin_x (o_out.new_spin_x),
    .i_new_spin_y (o_out.new_spin_y),
    .i_new_spin_z (o_out.new_spin_z)
);
